>>> sv/table_scan_bilinear_interp_assert.svh
// assertion macros for the table scan bilinear interpolation checker
// expects clk and arst_n in the scope of use
`ifndef TABLE_SCAN_BILINEAR_INTERP_ASSERT_SVH
`define TABLE_SCAN_BILINEAR_INTERP_ASSERT_SVH

// same-cycle implication
`define TSBI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSBI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tsbi_pkg.sv
// shared types and constants for the table scan bilinear interpolation block
// no dependencies
`default_nettype none

package tsbi_pkg;

	localparam int TSBI_FRAC_BITS = 16;

	localparam int W2_W   = 21;
	localparam int ANG_W  = 23;
	localparam int VAL_W  = 32;
	localparam int OUT_W  = 40;
	localparam int CFG_W  = 23;

	localparam int UNIT_W    = 64;
	localparam int DIV_W     = 32;
	localparam int MUL_STEPS = 24;

	localparam logic [ANG_W-1:0] TA_RESET  = 23'd1382810;
	localparam logic [W2_W-1:0]  TW2_RESET = 21'd327680;

	localparam logic [1:0] CFG_TARGET_ANGLE = 2'd0;
	localparam logic [1:0] CFG_TARGET_W2    = 2'd1;
	localparam logic [1:0] CFG_VALUE_SELECT = 2'd2;

	localparam logic [1:0] VSEL_BORN  = 2'd0;
	localparam logic [1:0] VSEL_RCI   = 2'd1;
	localparam logic [1:0] VSEL_RATIO = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NO_ANGLE,
		STAT_NO_BRACKET,
		STAT_BAD_WIDTH
	} tsbi_status_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} tsbi_op_t;

	typedef struct packed {
		logic     start;
		tsbi_op_t op;
	} tsbi_unit_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDIV,
		ST_UPD,
		ST_GO,
		ST_WAIT,
		ST_EMIT
	} tsbi_state_t;

endpackage

`default_nettype wire

>>> sv/tsbi_channels.sv
// channel interfaces: configuration writes, table rows, results
// depends on tsbi_pkg
`default_nettype none

interface tsbi_cfg_if import tsbi_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       index;
	logic [CFG_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface tsbi_row_if import tsbi_pkg::*;;
	logic             valid;
	logic             ready;
	logic [W2_W-1:0]  w2;
	logic [ANG_W-1:0] theta;
	logic [VAL_W-1:0] born;
	logic [VAL_W-1:0] rci;
	logic             last;
	modport source (output valid, w2, theta, born, rci, last, input ready);
	modport sink (input valid, w2, theta, born, rci, last, output ready);
endinterface

interface tsbi_res_if import tsbi_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] cross_section;
	logic [1:0]              status;
	modport source (output valid, cross_section, status, input ready);
	modport sink (input valid, cross_section, status, output ready);
endinterface

`default_nettype wire

>>> sv/tsbi_unit.sv
// shared iterative unit: shift-add multiply and restoring divide, one bit a cycle
// depends on tsbi_pkg
`default_nettype none

module tsbi_unit import tsbi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsbi_unit_req_t        req,
	input  logic [UNIT_W-1:0]     a,
	input  logic [DIV_W-1:0]      b,
	output logic                  done,
	output logic [UNIT_W-1:0]     res
);

	localparam int CNT_W = $clog2(UNIT_W + 1);

	logic             busy_q;
	logic             done_q;
	tsbi_op_t         op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [UNIT_W-1:0] acc_q;
	logic [UNIT_W-1:0] mcand_q;
	logic [DIV_W-1:0]  b_q;
	logic [DIV_W-1:0]  rem_q;

	logic [DIV_W:0] trial;
	logic           ge;

	assign trial = {rem_q, acc_q[UNIT_W-1]} - {1'b0, b_q};
	assign ge    = !trial[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? CNT_W'(UNIT_W) : CNT_W'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			b_q     <= b;
			mcand_q <= a;
			rem_q   <= '0;
			acc_q   <= (req.op == OP_DIV) ? a : '0;
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				rem_q <= ge ? trial[DIV_W-1:0] : {rem_q[DIV_W-2:0], acc_q[UNIT_W-1]};
				acc_q <= {acc_q[UNIT_W-2:0], ge};
			end else begin
				if (b_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q <= {mcand_q[UNIT_W-2:0], 1'b0};
				b_q     <= {1'b0, b_q[DIV_W-1:1]};
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

`default_nettype wire

>>> sv/table_scan_bilinear_interp.sv
// top level: row scan, bracket tracking and interpolation sequencer
// depends on tsbi_pkg, tsbi_channels, tsbi_unit
//
// channel   role    transfer when        payload
// cfg       sink    valid & ready        index, data
// row       sink    valid & ready        w2, theta, born, rci, last
// res       source  valid & ready        cross_section, status
//
// a row with value_select 2 and nonzero rci also runs a 64-step divide
// with ok status the last row adds six 24-step multiplies and three 64-step divides
// all multiplies and divides run through the one shared unit; row ready only when idle
// cfg is always ready; a waiting result holds while the next rows are scanned
// asynchronous reset restores config, scan and control state but not payload registers
`default_nettype none

module table_scan_bilinear_interp import tsbi_pkg::*; #(
	parameter int FRAC_BITS = TSBI_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	tsbi_cfg_if.sink  cfg,
	tsbi_row_if.sink  row,
	tsbi_res_if.source res
);

	localparam logic [ANG_W:0] ANGLE_TOL = (ANG_W+1)'(((2 << FRAC_BITS) + 5) / 10);
	localparam logic [1:0] GRP_LOW   = 2'd0;
	localparam logic [1:0] GRP_HIGH  = 2'd1;
	localparam logic [1:0] GRP_FINAL = 2'd2;
	localparam logic [1:0] K_FIRST   = 2'd0;
	localparam logic [1:0] K_SECOND  = 2'd1;
	localparam logic [1:0] K_DIV     = 2'd2;

	tsbi_state_t state_q, state_d;

	// configuration
	logic [ANG_W-1:0] ta_q;
	logic [W2_W-1:0]  tw2_q;
	logic [1:0]       sel_q;

	// captured row
	logic [W2_W-1:0]  w2_q;
	logic [ANG_W-1:0] theta_q;
	logic [VAL_W-1:0] born_q;
	logic [VAL_W-1:0] rci_q;
	logic             last_q;

	// scan state
	logic             laf_q, haf_q, lbf_q, hbf_q, rz_q;
	logic [ANG_W-1:0] la_q, ha_q;
	logic [W2_W-1:0]  bw2_q [4];
	logic [VAL_W-1:0] bv_q [4];
	logic [W2_W-1:0]  pw2_q;
	logic [VAL_W-1:0] pv_q;

	// interpolation
	logic [1:0]              grp_q, k_q;
	logic                    sgn_q;
	logic signed [64:0]      sum_q;
	logic signed [OUT_W-1:0] edge_q [2];
	logic signed [OUT_W-1:0] rslt_q;
	tsbi_status_t            stat_q;

	// result register
	logic                    rv_q;
	logic signed [OUT_W-1:0] out_cs_q;
	tsbi_status_t            out_st_q;

	// unit
	tsbi_unit_req_t      u_req;
	logic [UNIT_W-1:0]   u_a;
	logic [DIV_W-1:0]    u_b;
	logic                u_done;
	logic [UNIT_W-1:0]   u_res;

	tsbi_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.a      (u_a),
		.b      (u_b),
		.done   (u_done),
		.res    (u_res)
	);

	// row value and scan update
	logic signed [ANG_W:0] ang_diff, ang_neg;
	logic [ANG_W:0]        ang_abs;
	logic                  near, below;
	logic [VAL_W-1:0]      val;
	logic                  n_laf, n_haf, n_lbf, n_hbf, n_rz, take_lb, take_hb;
	logic [ANG_W-1:0]      n_la, n_ha;
	logic [W2_W-1:0]       n_bw2 [4];
	logic [VAL_W-1:0]      n_bv [4];
	tsbi_status_t          n_stat;

	always_comb begin
		ang_diff = signed'({1'b0, ta_q}) - signed'({1'b0, theta_q});
		ang_neg  = -ang_diff;
		ang_abs  = ang_diff[ANG_W] ? unsigned'(ang_neg) : unsigned'(ang_diff);
		near     = ang_abs <= ANGLE_TOL;
		below    = w2_q < tw2_q;
		case (sel_q)
			VSEL_RCI:   val = rci_q;
			VSEL_RATIO: val = (rci_q == '0) ? '1 :
				((|u_res[UNIT_W-1:VAL_W]) ? '1 : u_res[VAL_W-1:0]);
			default:    val = born_q;
		endcase
		n_laf   = laf_q | near;
		n_la    = (!laf_q && near) ? theta_q : la_q;
		take_lb = n_laf && (theta_q == n_la) && below && !lbf_q;
		n_lbf   = lbf_q | take_lb;
		n_haf   = haf_q | (near && n_laf && (theta_q != n_la));
		n_ha    = (!haf_q && near && n_laf && (theta_q != n_la)) ? theta_q : ha_q;
		take_hb = n_haf && (theta_q == n_ha) && below && !hbf_q;
		n_hbf   = hbf_q | take_hb;
		n_rz    = rz_q | ((sel_q == VSEL_RATIO) && (rci_q == '0));
		n_bw2   = bw2_q;
		n_bv    = bv_q;
		if (take_lb) begin
			n_bw2[0] = w2_q;
			n_bw2[1] = pw2_q;
			n_bv[0]  = val;
			n_bv[1]  = pv_q;
		end
		if (take_hb) begin
			n_bw2[2] = w2_q;
			n_bw2[3] = pw2_q;
			n_bv[2]  = val;
			n_bv[3]  = pv_q;
		end
		if (!n_laf || !n_haf)
			n_stat = STAT_NO_ANGLE;
		else if (!n_lbf || !n_hbf)
			n_stat = STAT_NO_BRACKET;
		else if ((n_bw2[0] == n_bw2[1]) || (n_bw2[2] == n_bw2[3]) || n_rz || (n_ha == n_la))
			n_stat = STAT_BAD_WIDTH;
		else
			n_stat = STAT_OK;
	end

	// operand selection for one interpolation line
	logic [ANG_W-1:0]        xa, xb, xt;
	logic signed [OUT_W:0]   za, zb, cur_z, z_neg;
	logic signed [ANG_W:0]   d_first, d_second, span, cur_d, d_neg;
	logic [OUT_W-1:0]        z_mag;
	logic [ANG_W:0]          d_mag;
	logic signed [64:0]      sum_neg, term, prod_s;
	logic [UNIT_W-1:0]       sum_mag, q_neg;
	logic signed [OUT_W-1:0] sat_val;

	always_comb begin
		case (grp_q)
			GRP_LOW: begin
				xa = ANG_W'(bw2_q[0]);
				xb = ANG_W'(bw2_q[1]);
				za = signed'((OUT_W+1)'(bv_q[0]));
				zb = signed'((OUT_W+1)'(bv_q[1]));
				xt = ANG_W'(tw2_q);
			end
			GRP_HIGH: begin
				xa = ANG_W'(bw2_q[2]);
				xb = ANG_W'(bw2_q[3]);
				za = signed'((OUT_W+1)'(bv_q[2]));
				zb = signed'((OUT_W+1)'(bv_q[3]));
				xt = ANG_W'(tw2_q);
			end
			default: begin
				xa = la_q;
				xb = ha_q;
				za = (OUT_W+1)'(edge_q[0]);
				zb = (OUT_W+1)'(edge_q[1]);
				xt = ta_q;
			end
		endcase
		d_first  = signed'({1'b0, xb}) - signed'({1'b0, xt});
		d_second = signed'({1'b0, xt}) - signed'({1'b0, xa});
		span     = signed'({1'b0, xb}) - signed'({1'b0, xa});
		case (k_q)
			K_FIRST:  cur_d = d_first;
			K_SECOND: cur_d = d_second;
			default:  cur_d = span;
		endcase
		cur_z   = (k_q == K_FIRST) ? za : zb;
		z_neg   = -cur_z;
		z_mag   = cur_z[OUT_W] ? z_neg[OUT_W-1:0] : cur_z[OUT_W-1:0];
		d_neg   = -cur_d;
		d_mag   = cur_d[ANG_W] ? unsigned'(d_neg) : unsigned'(cur_d);
		sum_neg = -sum_q;
		sum_mag = sum_q[64] ? sum_neg[UNIT_W-1:0] : sum_q[UNIT_W-1:0];
		prod_s  = signed'({1'b0, u_res});
		term    = sgn_q ? -prod_s : prod_s;
		q_neg   = -u_res;
		if (sgn_q)
			sat_val = (u_res > 64'h80_0000_0000) ? 40'sh80_0000_0000 : signed'(q_neg[OUT_W-1:0]);
		else
			sat_val = (u_res > 64'h7F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF : signed'(u_res[OUT_W-1:0]);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		u_req.start = 1'b0;
		u_req.op    = OP_DIV;
		u_a         = {32'b0, row.born} << FRAC_BITS;
		u_b         = row.rci;
		case (state_q)
			ST_IDLE: begin
				if (row.valid) begin
					if ((sel_q == VSEL_RATIO) && (row.rci != '0)) begin
						u_req.start = 1'b1;
						state_d     = ST_RDIV;
					end else begin
						state_d = ST_UPD;
					end
				end
			end
			ST_RDIV: begin
				if (u_done)
					state_d = ST_UPD;
			end
			ST_UPD: begin
				if (!last_q)
					state_d = ST_IDLE;
				else if (n_stat == STAT_OK)
					state_d = ST_GO;
				else
					state_d = ST_EMIT;
			end
			ST_GO: begin
				u_req.start = 1'b1;
				u_req.op    = (k_q == K_DIV) ? OP_DIV : OP_MUL;
				u_a         = (k_q == K_DIV) ? sum_mag : {24'b0, z_mag};
				u_b         = DIV_W'(d_mag);
				state_d     = ST_WAIT;
			end
			ST_WAIT: begin
				if (u_done)
					state_d = ((k_q == K_DIV) && (grp_q == GRP_FINAL)) ? ST_EMIT : ST_GO;
			end
			ST_EMIT: begin
				if (!rv_q || res.ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign row.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ta_q  <= TA_RESET;
			tw2_q <= TW2_RESET;
			sel_q <= VSEL_BORN;
			laf_q <= 1'b0;
			haf_q <= 1'b0;
			lbf_q <= 1'b0;
			hbf_q <= 1'b0;
			rz_q  <= 1'b0;
			la_q  <= '0;
			ha_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				bw2_q[i] <= '0;
				bv_q[i]  <= '0;
			end
			pw2_q  <= '1;
			pv_q   <= '1;
			grp_q  <= GRP_LOW;
			k_q    <= K_FIRST;
			rv_q   <= 1'b0;
			stat_q <= STAT_OK;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TARGET_ANGLE: ta_q  <= cfg.data;
					CFG_TARGET_W2:    tw2_q <= cfg.data[W2_W-1:0];
					CFG_VALUE_SELECT: sel_q <= cfg.data[1:0];
					default: ;
				endcase
			end
			if ((state_q == ST_EMIT) && (!rv_q || res.ready))
				rv_q <= 1'b1;
			else if (rv_q && res.ready)
				rv_q <= 1'b0;
			case (state_q)
				ST_UPD: begin
					laf_q  <= n_laf;
					haf_q  <= n_haf;
					lbf_q  <= n_lbf;
					hbf_q  <= n_hbf;
					rz_q   <= n_rz;
					la_q   <= n_la;
					ha_q   <= n_ha;
					bw2_q  <= n_bw2;
					bv_q   <= n_bv;
					pw2_q  <= w2_q;
					pv_q   <= val;
					stat_q <= n_stat;
					grp_q  <= GRP_LOW;
					k_q    <= K_FIRST;
				end
				ST_WAIT: begin
					if (u_done) begin
						if (k_q == K_DIV) begin
							k_q   <= K_FIRST;
							grp_q <= grp_q + 2'd1;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				ST_EMIT: begin
					if (!rv_q || res.ready) begin
						laf_q <= 1'b0;
						haf_q <= 1'b0;
						lbf_q <= 1'b0;
						hbf_q <= 1'b0;
						rz_q  <= 1'b0;
						la_q  <= '0;
						ha_q  <= '0;
						for (int i = 0; i < 4; i++) begin
							bw2_q[i] <= '0;
							bv_q[i]  <= '0;
						end
						pw2_q <= '1;
						pv_q  <= '1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (row.valid && row.ready) begin
			w2_q    <= row.w2;
			theta_q <= row.theta;
			born_q  <= row.born;
			rci_q   <= row.rci;
			last_q  <= row.last;
		end
		if (state_q == ST_UPD)
			rslt_q <= '0;
		if (state_q == ST_GO && k_q != K_DIV)
			sgn_q <= cur_z[OUT_W] ^ cur_d[ANG_W];
		if (state_q == ST_GO && k_q == K_DIV)
			sgn_q <= sum_q[64] ^ span[ANG_W];
		if (state_q == ST_WAIT && u_done) begin
			case (k_q)
				K_FIRST:  sum_q <= term;
				K_SECOND: sum_q <= sum_q + term;
				default: begin
					if (grp_q == GRP_FINAL)
						rslt_q <= sat_val;
					else
						edge_q[grp_q[0]] <= sat_val;
				end
			endcase
		end
		if (state_q == ST_EMIT && (!rv_q || res.ready)) begin
			out_cs_q <= rslt_q;
			out_st_q <= stat_q;
		end
	end

	assign res.valid         = rv_q;
	assign res.cross_section = out_cs_q;
	assign res.status        = out_st_q;

endmodule

`default_nettype wire

>>> sv/tsbi_checker.sv
// port-level checker for table_scan_bilinear_interp, bound to the top level
// depends on tsbi_pkg and table_scan_bilinear_interp_assert.svh
`default_nettype none

`include "table_scan_bilinear_interp_assert.svh"

module tsbi_checker import tsbi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    row_valid,
	input logic                    row_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic signed [OUT_W-1:0] res_cs,
	input logic [1:0]              res_status
);

	// row ready drops in the cycle after a row is taken
	`TSBI_ASSERT_NEXT(a_busy_after_row, row_valid && row_ready, !row_ready, "row ready after transfer")

	// failed tables report a zero value
	`TSBI_ASSERT_NOW(a_zero_on_fail, res_valid && (res_status != STAT_OK), res_cs == '0, "nonzero value with failure status")

	// a stalled result stays offered
	`TSBI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

endmodule

bind table_scan_bilinear_interp tsbi_checker u_tsbi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.row_valid  (row.valid),
	.row_ready  (row.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_cs     (res.cross_section),
	.res_status (res.status)
);

`default_nettype wire
